### hdl/dpf_pkg.sv
// ----------------------------------------------------------------------------
// dpf_pkg
// Shared types and constants of the duplicate packet filter.
// ----------------------------------------------------------------------------
package dpf_pkg;

    // APB address width: two 32-bit registers at byte offsets 0 and 4
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int ADDR_W  = 16;
    localparam int SEQ_W   = 8;
    localparam int BYTE_W  = 8;

    // Register index, taken from paddr[2]
    typedef logic [0:0] t_reg_idx;
    localparam t_reg_idx REG_OWN_ADDRESS_LOW = 1'b0;
    localparam t_reg_idx REG_SINK_ADDRESS    = 1'b1;

    // Configuration values handed to the datapath
    typedef struct packed {
        logic [BYTE_W-1:0] own_address_low;
        logic [BYTE_W-1:0] sink_address;
    } t_cfg;

    // Lookup outcome for the packet under work
    typedef struct packed {
        logic is_duplicate;
        logic new_sender;
    } t_lookup;

endpackage

### hdl/duplicate_packet_filter.sv
// ----------------------------------------------------------------------------
// duplicate_packet_filter
// Per-sender sequence number duplicate filter with APB configuration.
// ----------------------------------------------------------------------------
// A new packet beat can be taken in every clock cycle while the result side
// does not stall. A beat is captured in the input register, looked up against
// the sender table and written to the result register once that register is
// free or drains. A stalled result holds the input register, which then drops
// ready. The table lookup and its update happen in the same cycle, which lets
// the following packet see the updated table directly.
// The table is cleared at reset with no sweep.
module duplicate_packet_filter #(
    parameter int TABLE_ENTRIES = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // packet input
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [dpf_pkg::ADDR_W-1:0]  i_sender_address,
    input  logic [dpf_pkg::SEQ_W-1:0]   i_sequence_number,
    // result output
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_is_duplicate,
    output logic                        o_new_sender,
    output logic                        o_start_reply,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dpf_pkg::PADDR_W-1:0] paddr,
    input  logic [dpf_pkg::PDATA_W-1:0] pwdata,
    output logic [dpf_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);

    dpf_pkg::t_cfg              cfg;
    dpf_pkg::t_lookup           lookup;

    logic                       r_in_valid;
    logic [dpf_pkg::ADDR_W-1:0] r_in_addr;
    logic [dpf_pkg::SEQ_W-1:0]  r_in_seq;
    logic                       r_out_valid;
    logic                       r_out_dup;
    logic                       r_out_fresh;
    logic                       r_out_reply;
    logic                       advance;
    logic                       not_sink;

    dpf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dpf_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_addr   (r_in_addr),
        .i_seq    (r_in_seq),
        .i_update (advance),
        .o_lookup (lookup)
    );

    // handshake: input stage moves when the result register is free or drains
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign not_sink   = (cfg.own_address_low != cfg.sink_address);

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) r_in_valid <= i_in_valid;
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // input capture
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_addr <= i_sender_address;
            r_in_seq  <= i_sequence_number;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_dup   <= lookup.is_duplicate;
            r_out_fresh <= lookup.new_sender;
            r_out_reply <= !lookup.is_duplicate && not_sink;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_is_duplicate = r_out_dup;
    assign o_new_sender   = r_out_fresh;
    assign o_start_reply  = r_out_reply;

    // a duplicate is never a new sender
    a_dup_not_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_dup && r_out_fresh))
        else $error("duplicate flagged for a new sender");

    // a duplicate never asks for a reply
    a_dup_no_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_dup |-> !r_out_reply)
        else $error("reply requested for a duplicate");

    // a held input beat keeps its payload while the result side stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_addr) && $stable(r_in_seq))
        else $error("input stage lost a held beat");

    // result register is only replaced after it was taken or empty
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |-> !advance)
        else $error("result overwritten while stalled");

endmodule

### hdl/dpf_cfg.sv
// ----------------------------------------------------------------------------
// dpf_cfg
// APB register file: own address low byte and sink address.
// ----------------------------------------------------------------------------
module dpf_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [dpf_pkg::PADDR_W-1:0] paddr,
    input  logic [dpf_pkg::PDATA_W-1:0] pwdata,
    output logic [dpf_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    output dpf_pkg::t_cfg               o_cfg
);

    logic [dpf_pkg::BYTE_W-1:0] r_own;
    logic [dpf_pkg::BYTE_W-1:0] r_sink;
    logic                       wr_en;
    dpf_pkg::t_reg_idx          reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[2];

    // register writes on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own  <= '0;
            r_sink <= dpf_pkg::BYTE_W'(1);
        end else if (wr_en) begin
            unique case (reg_idx)
                dpf_pkg::REG_OWN_ADDRESS_LOW: r_own  <= pwdata[dpf_pkg::BYTE_W-1:0];
                dpf_pkg::REG_SINK_ADDRESS:    r_sink <= pwdata[dpf_pkg::BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            dpf_pkg::REG_OWN_ADDRESS_LOW: prdata[dpf_pkg::BYTE_W-1:0] = r_own;
            dpf_pkg::REG_SINK_ADDRESS:    prdata[dpf_pkg::BYTE_W-1:0] = r_sink;
            default: ;
        endcase
    end

    assign o_cfg.own_address_low = r_own;
    assign o_cfg.sink_address    = r_sink;

endmodule

### hdl/dpf_table.sv
// ----------------------------------------------------------------------------
// dpf_table
// Sender table: parallel address match, sequence compare, FIFO replacement.
// ----------------------------------------------------------------------------
module dpf_table #(
    parameter int TABLE_ENTRIES = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [dpf_pkg::ADDR_W-1:0] i_addr,
    input  logic [dpf_pkg::SEQ_W-1:0]  i_seq,
    input  logic                       i_update,
    output dpf_pkg::t_lookup           o_lookup
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic [dpf_pkg::ADDR_W-1:0] r_addr [TABLE_ENTRIES];
    logic [dpf_pkg::SEQ_W-1:0]  r_seq  [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0]   r_valid;
    logic [IDX_W-1:0]           r_ptr;
    logic [IDX_W-1:0]           n_ptr;

    logic [TABLE_ENTRIES-1:0]   match;
    logic [TABLE_ENTRIES-1:0]   seq_eq;
    logic [TABLE_ENTRIES-1:0]   free;
    logic [TABLE_ENTRIES-1:0]   free_low;
    logic [TABLE_ENTRIES-1:0]   ptr_oh;
    logic [TABLE_ENTRIES-1:0]   slot_oh;
    logic [TABLE_ENTRIES-1:0]   we_seq;
    logic [TABLE_ENTRIES-1:0]   we_new;
    logic                       hit;
    logic                       dup;
    logic                       any_free;

    // per-entry compares; at most one entry matches
    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            match[i]  = r_valid[i] && (r_addr[i] == i_addr);
            seq_eq[i] = match[i] && (r_seq[i] == i_seq);
            ptr_oh[i] = (r_ptr == IDX_W'(i));
        end
    end

    assign hit      = |match;
    assign dup      = |seq_eq;
    assign free     = ~r_valid;
    assign any_free = |free;
    // isolate lowest free slot
    assign free_low = free & (~free + TABLE_ENTRIES'(1));
    assign slot_oh  = any_free ? free_low : ptr_oh;

    assign we_seq = i_update ? ((hit && !dup) ? match : (hit ? '0 : slot_oh)) : '0;
    assign we_new = (i_update && !hit) ? slot_oh : '0;

    // replace pointer moves only when a full table takes a new sender
    always_comb begin
        n_ptr = r_ptr;
        if (i_update && !hit && !any_free) begin
            n_ptr = (r_ptr == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : r_ptr + IDX_W'(1);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_ptr   <= '0;
        end else begin
            r_valid <= r_valid | we_new;
            r_ptr   <= n_ptr;
        end
    end

    // entry payload
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (we_new[i]) r_addr[i] <= i_addr;
            if (we_seq[i]) r_seq[i]  <= i_seq;
        end
    end

    assign o_lookup.is_duplicate = dup;
    assign o_lookup.new_sender   = !hit;

endmodule
